// ===== hw/rtl/tts_pkg.sv =====
// Shared constants, types and helper functions of the tick task scheduler.
package tts_pkg;

  localparam int TASK_COUNT  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CREATE  = 3'd1;
  localparam logic [2:0] ACT_SUSPEND = 3'd2;
  localparam logic [2:0] ACT_RESUME  = 3'd3;
  localparam logic [2:0] ACT_DELETE  = 3'd4;

  typedef logic [SLOT_W-1:0] slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  apply_act;    // carry out a non-tick action on the accepted item
    logic  step_slot;    // update the countdown of the slot under scan
    slot_t slot;         // slot under scan
    logic  push_fire;    // place a release of the scanned slot in the pending stage
    logic  move_out;     // transfer the pending result into the output register
    logic  out_last;     // the result moved out ends its item
    logic  idle_result;  // nothing pending: send the no-release result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_release;  // scanned slot releases its task this tick
    logic pend_valid;    // pending stage holds a result
    logic out_free;      // output register can take a result this cycle
  } dp_stat_t;

  // Slot number of a task index, widened or cut to the slot width.
  function automatic slot_t slot_of(input logic [2:0] idx);
    logic [SLOT_W+2:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

  // True when a task index names an existing slot.
  function automatic logic index_ok(input logic [2:0] idx);
    logic [SLOT_W+2:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide < (SLOT_W + 3)'(TASK_COUNT);
  endfunction

  // Low three bits of a slot number, as reported on the result channel.
  function automatic logic [2:0] index_of(input slot_t slot);
    logic [SLOT_W+2:0] wide;
    wide = {3'b000, slot};
    return wide[2:0];
  endfunction

endpackage

// ===== hw/rtl/tts_if.sv =====
// Valid/ready channel interfaces for the scheduler's actions and results.
interface tts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  task_index;
  logic [15:0] period;
  logic [15:0] first_delay;

  modport source (output valid, action, task_index, period, first_delay, input ready);
  modport sink   (input valid, action, task_index, period, first_delay, output ready);
endinterface

interface tts_out_if;
  logic       valid;
  logic       ready;
  logic       task_fired;
  logic [2:0] fired_index;
  logic       status;
  logic       last;

  modport source (output valid, task_fired, fired_index, status, last, input ready);
  modport sink   (input valid, task_fired, fired_index, status, last, output ready);
endinterface

// ===== hw/rtl/tts_ctrl.sv =====
// Controller state machine: accepts actions, sequences the slot scan of a tick.
module tts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_action,
  output logic              in_ready,
  input  tts_pkg::dp_stat_t stat,
  output tts_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                state_r, state_nxt;
  tts_pkg::slot_t            slot_r, slot_nxt;
  logic [tts_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      want_emit;
  logic                      blocked;
  logic                      last_slot;

  assign want_emit = stat.slot_release && (cnt_r < tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS));
  // A second release cannot enter while the one ahead of it cannot move out.
  assign blocked   = want_emit && stat.pend_valid && !stat.out_free;
  assign last_slot = (slot_r == tts_pkg::SLOT_W'(tts_pkg::TASK_COUNT - 1));

  always_comb begin
    state_nxt       = state_r;
    slot_nxt        = slot_r;
    cnt_nxt         = cnt_r;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.slot        = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == tts_pkg::ACT_TICK) begin
            state_nxt = ST_SCAN;
            slot_nxt  = '0;
            cnt_nxt   = '0;
          end else begin
            cmd.apply_act = 1'b1;
            state_nxt     = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (!blocked) begin
          cmd.step_slot = 1'b1;
          cmd.push_fire = want_emit;
          cmd.move_out  = want_emit && stat.pend_valid;
          if (want_emit) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (last_slot) begin
            state_nxt = ST_FINISH;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.move_out    = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.idle_result = !stat.pend_valid;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/tts_datapath.sv =====
// Datapath: slot table, countdown update, pending result stage and output register.
module tts_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_action,
  input  logic [2:0]        in_task_index,
  input  logic [15:0]       in_period,
  input  logic [15:0]       in_first_delay,
  input  tts_pkg::ctl_cmd_t cmd,
  output tts_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_task_fired,
  output logic [2:0]        out_fired_index,
  output logic              out_status,
  output logic              out_last
);

  logic [tts_pkg::TASK_COUNT-1:0] installed_r;
  logic [tts_pkg::TASK_COUNT-1:0] running_r;
  logic [15:0]                    reload_r [tts_pkg::TASK_COUNT];
  logic [15:0]                    countdown_r [tts_pkg::TASK_COUNT];

  logic       pend_valid_r;
  logic       pend_fired_r;
  logic [2:0] pend_index_r;
  logic       pend_status_r;

  logic       out_valid_r;
  logic       out_fired_r;
  logic [2:0] out_index_r;
  logic       out_status_r;
  logic       out_last_r;

  tts_pkg::slot_t a_slot;
  logic           a_ok;
  logic           create_ok;
  logic [15:0]    scan_cd;
  logic           scan_run;
  logic           out_free;

  assign a_slot    = tts_pkg::slot_of(in_task_index);
  assign a_ok      = tts_pkg::index_ok(in_task_index);
  assign create_ok = a_ok && !installed_r[a_slot];
  assign scan_cd   = countdown_r[cmd.slot];
  assign scan_run  = running_r[cmd.slot];
  assign out_free  = !out_valid_r || out_ready;

  assign stat.slot_release = scan_run && (scan_cd == 16'd0) && installed_r[cmd.slot];
  assign stat.pend_valid   = pend_valid_r;
  assign stat.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      installed_r   <= '0;
      running_r     <= '0;
      for (int i = 0; i < tts_pkg::TASK_COUNT; i++) begin
        reload_r[i]    <= '0;
        countdown_r[i] <= '0;
      end
      pend_valid_r  <= 1'b0;
      pend_fired_r  <= 1'b0;
      pend_index_r  <= '0;
      pend_status_r <= 1'b0;
      out_valid_r   <= 1'b0;
      out_fired_r   <= 1'b0;
      out_index_r   <= '0;
      out_status_r  <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      if (cmd.apply_act) begin
        unique case (in_action)
          tts_pkg::ACT_CREATE: begin
            if (create_ok) begin
              installed_r[a_slot] <= 1'b1;
              running_r[a_slot]   <= 1'b1;
              reload_r[a_slot]    <= in_period;
              countdown_r[a_slot] <= in_first_delay;
            end
          end
          tts_pkg::ACT_SUSPEND: begin
            if (a_ok) begin
              running_r[a_slot] <= 1'b0;
            end
          end
          tts_pkg::ACT_RESUME: begin
            if (a_ok) begin
              running_r[a_slot] <= 1'b1;
            end
          end
          tts_pkg::ACT_DELETE: begin
            if (a_ok) begin
              installed_r[a_slot] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // A released slot reloads with period minus one; an empty slot stays at zero.
      if (cmd.step_slot && scan_run) begin
        if (scan_cd == 16'd0) begin
          if (installed_r[cmd.slot]) begin
            countdown_r[cmd.slot] <= reload_r[cmd.slot] - 16'd1;
          end
        end else begin
          countdown_r[cmd.slot] <= scan_cd - 16'd1;
        end
      end

      if (cmd.push_fire) begin
        pend_valid_r  <= 1'b1;
        pend_fired_r  <= 1'b1;
        pend_index_r  <= tts_pkg::index_of(cmd.slot);
        pend_status_r <= 1'b0;
      end else if (cmd.apply_act) begin
        pend_valid_r  <= 1'b1;
        pend_fired_r  <= 1'b0;
        pend_index_r  <= '0;
        pend_status_r <= (in_action == tts_pkg::ACT_CREATE) && !create_ok;
      end else if (cmd.move_out) begin
        pend_valid_r  <= 1'b0;
      end

      if (cmd.move_out) begin
        out_valid_r  <= 1'b1;
        out_fired_r  <= cmd.idle_result ? 1'b0 : pend_fired_r;
        out_index_r  <= cmd.idle_result ? 3'd0 : pend_index_r;
        out_status_r <= cmd.idle_result ? 1'b0 : pend_status_r;
        out_last_r   <= cmd.out_last;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_task_fired  = out_fired_r;
  assign out_fired_index = out_index_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

// ===== hw/rtl/tick_task_scheduler.sv =====
// Top level of the tick task scheduler: controller, datapath and channel wiring.
//
//   Channel   Direction  Transfer carries
//   in_ch     sink       action, task_index, period, first_delay
//   out_ch    source     task_fired, fired_index, status, last
//
// Create, suspend, resume and delete are applied on transfer; their single result
// waits in the pending stage until the output register is free. For a tick, the
// controller walks the slot table one slot per cycle while no release is blocked,
// then closes the item with a final result once the output register is free.
// The output register holds a result until it is taken; a stalled output stops
// the scan only when a second release finds the pending stage still occupied.
// Reset is synchronous and clears the whole slot table, so no task is installed.
module tick_task_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  tts_in_if.sink     in_ch,
  tts_out_if.source  out_ch
);

  tts_pkg::ctl_cmd_t cmd;
  tts_pkg::dp_stat_t stat;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tts_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_task_index   (in_ch.task_index),
    .in_period       (in_ch.period),
    .in_first_delay  (in_ch.first_delay),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_task_fired  (out_ch.task_fired),
    .out_fired_index (out_ch.fired_index),
    .out_status      (out_ch.status),
    .out_last        (out_ch.last)
  );

endmodule

// ===== hw/rtl/tts_checker.sv =====
// Port-level checker for the tick task scheduler and its bind statement.
module tts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_task_fired,
  input logic [2:0] out_fired_index,
  input logic       out_status,
  input logic       out_last
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_task_fired)
      && $stable(out_fired_index) && $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  // Once an action is transferred, no further action is taken until it is done.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second action taken while one is in progress");

  // A result that releases nothing is always the only one for its item.
  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_task_fired |-> out_last && (out_fired_index == 3'd0))
    else $error("no-release result not final or index not zero");

  // A refused create never also reports a release.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_task_fired && out_last)
    else $error("status set on a release result");

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_task_fired  (out_ch.task_fired),
  .out_fired_index (out_ch.fired_index),
  .out_status      (out_ch.status),
  .out_last        (out_ch.last)
);
